>>> design/signed_int_to_decimal_ascii_core_macros.svh
// assertion macros used by the datapath design file
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef SYNTH
`define SITOA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sitoa assertion failed");
`define SITOA_NEVER(label, clk, rst_n, prop) \
    `SITOA_ASSERT(label, clk, rst_n, !(prop))
`else
`define SITOA_ASSERT(label, clk, rst_n, prop)
`define SITOA_NEVER(label, clk, rst_n, prop)
`endif
`endif

>>> design/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// types and constants for the signed integer to decimal ascii converter
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [3:0] POS_TOP    = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic step_digit;
    } t_cmd;

    typedef struct packed {
        logic in_neg;
        logic out_free;
        logic pos_zero;
    } t_status;

    // d times ten to the power pos, wide enough for nine billion
    function automatic logic [33:0] pow_mult(input logic [3:0] pos, input logic [3:0] d);
        logic [33:0] dd;
        logic [33:0] r;
        dd = {30'd0, d};
        case (pos)
            4'd0:    r = dd;
            4'd1:    r = dd * 34'd10;
            4'd2:    r = dd * 34'd100;
            4'd3:    r = dd * 34'd1000;
            4'd4:    r = dd * 34'd10000;
            4'd5:    r = dd * 34'd100000;
            4'd6:    r = dd * 34'd1000000;
            4'd7:    r = dd * 34'd10000000;
            4'd8:    r = dd * 34'd100000000;
            4'd9:    r = dd * 34'd1000000000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> design/sitoa_ctrl.sv
// ----------------------------------------------------------------------------
// sitoa_ctrl
// sequencer: takes a word, emits the sign if negative, then walks the ten decimal positions
// ----------------------------------------------------------------------------
module sitoa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sitoa_pkg::t_status i_status,
    output sitoa_pkg::t_cmd    o_cmd
);

    sitoa_pkg::t_state r_state;
    sitoa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sitoa_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.in_neg ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_DIGITS;
                end
            end
            sitoa_pkg::ST_SIGN: begin
                if (i_status.out_free) begin
                    n_state = sitoa_pkg::ST_DIGITS;
                end
            end
            sitoa_pkg::ST_DIGITS: begin
                if (i_status.out_free && i_status.pos_zero) begin
                    n_state = sitoa_pkg::ST_IDLE;
                end
            end
            default: n_state = sitoa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            sitoa_pkg::ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            sitoa_pkg::ST_SIGN: begin
                o_cmd.emit_sign = i_status.out_free;
            end
            sitoa_pkg::ST_DIGITS: begin
                o_cmd.step_digit = i_status.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

>>> design/sitoa_dp.sv
// ----------------------------------------------------------------------------
// sitoa_dp
// magnitude register, one decimal digit per step, output register
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitoa_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_value,
    input  sitoa_pkg::t_cmd    i_cmd,
    output sitoa_pkg::t_status o_status,
    output logic               o_valid,
    output logic [7:0]         o_char_code,
    output logic               o_last,
    input  logic               i_stall
);

    logic [31:0] r_mag;
    logic [31:0] n_mag;
    logic [3:0]  r_pos;
    logic        r_started;
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;

    logic [3:0]  digit;
    logic [33:0] sub_val;
    logic        emit_digit;
    logic [31:0] in_raw;

    assign in_raw = i_value;

    // digit at the current position by comparing against its nine multiples
    always_comb begin
        digit = 4'd0;
        for (int d = 1; d < 10; d++) begin
            if ({2'b00, r_mag} >= sitoa_pkg::pow_mult(r_pos, 4'(d))) begin
                digit = 4'(d);
            end
        end
        sub_val = sitoa_pkg::pow_mult(r_pos, digit);
        n_mag   = r_mag - sub_val[31:0];
    end

    // leading zeros are skipped, the units digit always goes out
    assign emit_digit = i_cmd.step_digit &&
                        ((digit != 4'd0) || r_started || (r_pos == 4'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_pos       <= sitoa_pkg::POS_TOP;
        end else begin
            if (i_cmd.load) begin
                r_mag     <= in_raw[31] ? (32'd0 - in_raw) : in_raw;
                r_pos     <= sitoa_pkg::POS_TOP;
                r_started <= 1'b0;
            end else if (i_cmd.step_digit) begin
                r_mag <= n_mag;
                r_pos <= r_pos - 4'd1;
                if (emit_digit) begin
                    r_started <= 1'b1;
                end
            end

            if (i_cmd.emit_sign) begin
                r_out_valid <= 1'b1;
                r_char      <= sitoa_pkg::CHAR_MINUS;
                r_last      <= 1'b0;
            end else if (emit_digit) begin
                r_out_valid <= 1'b1;
                r_char      <= sitoa_pkg::CHAR_ZERO + {4'd0, digit};
                r_last      <= (r_pos == 4'd0);
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.in_neg   = i_value[31];
    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_status.pos_zero = (r_pos == 4'd0);

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    `SITOA_ASSERT(a_units_is_last, i_clk, i_rst_n, (i_cmd.step_digit && (r_pos == 4'd0)) |=> (o_valid && o_last))
    `SITOA_ASSERT(a_sign_not_last, i_clk, i_rst_n, i_cmd.emit_sign |=> (o_valid && !o_last && (o_char_code == sitoa_pkg::CHAR_MINUS)))
    `SITOA_ASSERT(a_char_legal, i_clk, i_rst_n, o_valid |-> ((o_char_code == sitoa_pkg::CHAR_MINUS) || ((o_char_code >= sitoa_pkg::CHAR_ZERO) && (o_char_code <= sitoa_pkg::CHAR_NINE))))
    `SITOA_NEVER(a_no_overwrite, i_clk, i_rst_n, (i_cmd.emit_sign || i_cmd.step_digit) && r_out_valid && i_stall)

endmodule

>>> design/signed_int_to_decimal_ascii_core.sv
// first character: registered from the sign or digit state that follows the load, zeros skipped
// a new word is taken only in idle, once the units digit of the previous word has been registered
// the digit loop walks ten decimal positions, one per cycle while the output register is free
// each character is held in the output register until it is taken
// reset: synchronous active-low, clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// 32-bit two's-complement word in, decimal ascii text out, most significant first
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_value,
    output logic               o_stall,
    output logic               o_valid,
    output logic [7:0]         o_char_code,
    output logic               o_last,
    input  logic               i_stall
);

    sitoa_pkg::t_cmd    cmd;
    sitoa_pkg::t_status status;

    sitoa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sitoa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

endmodule

>>> verif/signed_int_to_decimal_ascii_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_test
// drives 32-bit signed words into the converter and checks every ascii
// character and its last flag against a local predictor, under random
// sender gaps, receiver stalls, a long receiver hold-off and a drain pause
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_test;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_ascii_char;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic signed [31:0] i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [7:0]         o_char_code;
    logic               o_last;

    t_ascii_char text_q[$];
    t_ascii_char want;
    int          err_count   = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_cycles = 0;
    int          hold_req    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    signed_int_to_decimal_ascii_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // expected text of one word, minus sign first, last flag on the final digit
    function automatic void predict_text(input logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  digs[10];
        int          nd;
        mag = raw[31] ? (32'd0 - raw) : raw;
        nd  = 0;
        do begin
            digs[nd] = sitoa_pkg::CHAR_ZERO + 8'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 0 && nd < 10);
        if (raw[31]) begin
            text_q.push_back('{sitoa_pkg::CHAR_MINUS, 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--) begin
            text_q.push_back('{digs[i], i == 0});
        end
    endfunction

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = hold_cycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (text_q.size() == 0) begin
                $error("char_code: no character expected, got %0d", o_char_code);
                err_count++;
            end else begin
                want = text_q.pop_front();
                if (o_char_code !== want.code) begin
                    $error("char_code: expected %0d, got %0d", want.code, o_char_code);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    task automatic send_word(input logic [31:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        predict_text(v);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(3))
            0: w = w;
            1: w = w >> $urandom_range(31);
            2: w = 32'd0 - (w >> $urandom_range(31));
            default: begin
                w = $urandom_range(999);
                if ($urandom_range(1)) w = 32'd0 - w;
            end
        endcase
        return w;
    endfunction

    task automatic test_directed();
        logic [31:0] vals[$];
        vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'd1000000000, -32'sd999999999, 32'd123456789, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd4294967286, 32'd0};
        foreach (vals[k]) send_word(vals[k]);
        end_stream();
        wait_drained();
    endtask

    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_word(rand_value());
        end_stream();
        wait_drained();
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_receiver_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_cycles  = 150;
        hold_req++;
        repeat (12) send_word(rand_value());
        end_stream();
        wait_drained();
    endtask

    // sender stops until all text is out, then resumes
    task automatic test_sender_pause();
        tx_idle_pct  = 12;
        rx_stall_pct = 30;
        repeat (6) send_word(rand_value());
        end_stream();
        wait_drained();
        repeat (6) send_word(rand_value());
        end_stream();
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(75, 12, 50);
        test_random(75, 50, 12);
        test_receiver_hold();
        test_sender_pause();
        test_random(45, 0, 0);

        repeat (30) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/sitoa_pkg.sv
design/sitoa_ctrl.sv
design/sitoa_dp.sv
design/signed_int_to_decimal_ascii_core.sv
verif/signed_int_to_decimal_ascii_core_test.sv
